FILE: hdl/rpc_record_mark_deframer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the record-mark deframer checker
// ---------------------------------------------------------------------------
`ifndef RPC_RECORD_MARK_DEFRAMER_MACROS_SVH
`define RPC_RECORD_MARK_DEFRAMER_MACROS_SVH

// same-cycle implication, held off during reset
`define RPCRMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpcrmd: implication check failed");

// next-cycle implication, held off during reset
`define RPCRMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpcrmd: next-cycle check failed");

`endif

FILE: hdl/rpcrmd_pkg.sv
// ---------------------------------------------------------------------------
// rpcrmd_pkg
// Types and constants shared by the record-mark deframer files.
// ---------------------------------------------------------------------------
package rpcrmd_pkg;

    localparam int RECORD_LENGTH_BITS = 24;
    localparam int FRAG_LEN_BITS      = 31;
    localparam int MARKER_HELD_BITS   = 24;

    localparam logic [RECORD_LENGTH_BITS-1:0] LEN_MASK = '1;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_LIMIT   = 2'd1,
        STATUS_REFUSED = 2'd2
    } status_t;

    // fragment_left never exceeds the limit, so it fits the record width
    typedef struct packed {
        logic [MARKER_HELD_BITS-1:0]   marker_bytes;
        logic [1:0]                    marker_count;
        logic [RECORD_LENGTH_BITS-1:0] fragment_left;
        logic                          last_fragment;
        logic [RECORD_LENGTH_BITS-1:0] record_total;
        logic                          record_open;
        logic                          stream_failed;
    } deframe_state_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       record_end;
        status_t    status;
        logic       at_boundary;
    } result_t;

endpackage

FILE: hdl/rpcrmd_in_if.sv
// ---------------------------------------------------------------------------
// rpcrmd_in_if
// Byte stream channel into the deframer.
// ---------------------------------------------------------------------------
interface rpcrmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: hdl/rpcrmd_out_if.sv
// ---------------------------------------------------------------------------
// rpcrmd_out_if
// Result channel out of the deframer.
// ---------------------------------------------------------------------------
interface rpcrmd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       record_end;
    logic [1:0] status;
    logic       at_boundary;

    modport source (output valid, output payload_valid, output payload_byte,
                    output record_end, output status, output at_boundary,
                    input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input record_end, input status, input at_boundary,
                    output ready);
endinterface

FILE: hdl/rpcrmd_step.sv
// ---------------------------------------------------------------------------
// rpcrmd_step
// Next state and result for one stream byte: marker collection, limit check
// and payload countdown.
// ---------------------------------------------------------------------------
module rpcrmd_step
    import rpcrmd_pkg::*;
(
    input  deframe_state_t                cur,
    input  logic [7:0]                    in_byte,
    input  logic [RECORD_LENGTH_BITS-1:0] max_bytes,
    output deframe_state_t                nxt,
    output result_t                       res
);

    logic [FRAG_LEN_BITS-1:0]      frag_len;
    logic                          frag_fin;
    logic [RECORD_LENGTH_BITS:0]   total_sum;
    logic                          over_limit;
    logic [RECORD_LENGTH_BITS-1:0] left_dec;

    assign frag_len  = {cur.marker_bytes[FRAG_LEN_BITS-9:0], in_byte};
    assign frag_fin  = cur.marker_bytes[MARKER_HELD_BITS-1];
    assign total_sum = {1'b0, cur.record_total} + {1'b0, frag_len[RECORD_LENGTH_BITS-1:0]};
    // total + len > max also covers len > max on its own
    assign over_limit = (frag_len[FRAG_LEN_BITS-1:RECORD_LENGTH_BITS] != '0)
                     || (total_sum > {1'b0, max_bytes});
    assign left_dec  = cur.fragment_left - RECORD_LENGTH_BITS'(1);

    always_comb
    begin
        nxt = cur;
        res = '{payload_valid: 1'b0, payload_byte: 8'd0, record_end: 1'b0,
                status: STATUS_OK, at_boundary: 1'b0};

        priority if (cur.stream_failed)
        begin
            res.status = STATUS_REFUSED;
        end
        else if (cur.fragment_left == '0)
        begin
            if (cur.marker_count != 2'd3)
            begin
                nxt.marker_bytes = {cur.marker_bytes[MARKER_HELD_BITS-9:0], in_byte};
                nxt.marker_count = cur.marker_count + 2'd1;
            end
            else
            begin
                nxt.marker_bytes = '0;
                nxt.marker_count = 2'd0;
                if (over_limit)
                begin
                    nxt.stream_failed = 1'b1;
                    res.status        = STATUS_LIMIT;
                end
                else
                begin
                    nxt.fragment_left = frag_len[RECORD_LENGTH_BITS-1:0];
                    nxt.last_fragment = frag_fin;
                    nxt.record_open   = 1'b1;
                    // empty final fragment closes the record on its marker
                    if (frag_len == '0 && frag_fin)
                    begin
                        res.record_end    = 1'b1;
                        nxt.record_total  = '0;
                        nxt.record_open   = 1'b0;
                        nxt.last_fragment = 1'b0;
                    end
                end
            end
        end
        else
        begin
            res.payload_valid = 1'b1;
            res.payload_byte  = in_byte;
            nxt.record_total  = cur.record_total + RECORD_LENGTH_BITS'(1);
            nxt.fragment_left = left_dec;
            if (left_dec == '0 && cur.last_fragment)
            begin
                res.record_end    = 1'b1;
                nxt.record_total  = '0;
                nxt.record_open   = 1'b0;
                nxt.last_fragment = 1'b0;
            end
        end

        res.at_boundary = !nxt.stream_failed && nxt.marker_count == 2'd0
                       && nxt.fragment_left == '0 && !nxt.record_open
                       && nxt.record_total == '0;
    end

endmodule

FILE: hdl/rpc_record_mark_deframer.sv
// ---------------------------------------------------------------------------
// rpc_record_mark_deframer
// Streams the payload of a record-marked byte stream, one byte per word,
// flagging record ends and enforcing a record size limit.
// ---------------------------------------------------------------------------
//  channel  dir  word contents
//  in_ch    in   in_byte
//  out_ch   out  payload_valid, payload_byte, record_end, status, at_boundary
//  cfg      in   cfg_we / cfg_wdata: max_record_bytes (0 means all ones)
//
//  One word per cycle unless out_ch stalls; path: input reg, then result reg.
//  The per-byte state update is combinational between those two registers.
//  Reset clears all deframer state and sets the limit to all ones.
//  A stall on out_ch backs up through the input register to in_ch.ready.
// ---------------------------------------------------------------------------
module rpc_record_mark_deframer
    import rpcrmd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    rpcrmd_in_if.sink                     in_ch,
    rpcrmd_out_if.source                  out_ch,
    input  logic                          cfg_we,
    input  logic [RECORD_LENGTH_BITS-1:0] cfg_wdata
);

    logic                          in_vld_reg;
    logic [7:0]                    in_byte_reg;
    logic                          out_vld_reg;
    result_t                       res_reg;
    deframe_state_t                state_reg;
    deframe_state_t                state_next;
    result_t                       res_next;
    logic [RECORD_LENGTH_BITS-1:0] max_reg;
    logic                          out_load;
    logic                          advance;
    logic                          in_take;

    assign out_load    = !out_vld_reg || out_ch.ready;
    assign advance     = in_vld_reg && out_load;
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    rpcrmd_step u_step (
        .cur       (state_reg),
        .in_byte   (in_byte_reg),
        .max_bytes (max_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
            max_reg     <= LEN_MASK;
        end
        else
        begin
            if (in_ch.ready)
                in_vld_reg <= in_ch.valid;
            if (out_load)
                out_vld_reg <= in_vld_reg;
            if (advance)
                state_reg <= state_next;
            if (cfg_we)
                max_reg <= (cfg_wdata == '0) ? LEN_MASK : cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= in_ch.in_byte;
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.payload_valid = res_reg.payload_valid;
    assign out_ch.payload_byte  = res_reg.payload_byte;
    assign out_ch.record_end    = res_reg.record_end;
    assign out_ch.status        = res_reg.status;
    assign out_ch.at_boundary   = res_reg.at_boundary;

endmodule

FILE: hdl/rpcrmd_checker.sv
// ---------------------------------------------------------------------------
// rpcrmd_checker
// Port-level checks on the deframer result channel.
// ---------------------------------------------------------------------------
`include "rpc_record_mark_deframer_macros.svh"

module rpcrmd_checker
    import rpcrmd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       payload_valid,
    input logic [7:0] payload_byte,
    input logic       record_end,
    input logic [1:0] status,
    input logic       at_boundary
);

    logic [11:0] word;
    assign word = {payload_valid, payload_byte, record_end, status};

    `RPCRMD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(word) && $stable(at_boundary))
    `RPCRMD_ASSERT_IMPLY(a_byte_zero, clk, rst_n, out_valid && !payload_valid, payload_byte == 8'd0)
    `RPCRMD_ASSERT_IMPLY(a_refused_quiet, clk, rst_n, out_valid && status == STATUS_REFUSED, !payload_valid && !record_end && !at_boundary)
    `RPCRMD_ASSERT_IMPLY(a_limit_no_data, clk, rst_n, out_valid && status == STATUS_LIMIT, !payload_valid && !record_end && !at_boundary)
    `RPCRMD_ASSERT_IMPLY(a_end_boundary, clk, rst_n, out_valid && record_end, at_boundary && status == STATUS_OK)

endmodule

bind rpc_record_mark_deframer rpcrmd_checker u_rpcrmd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .payload_valid (out_ch.payload_valid),
    .payload_byte  (out_ch.payload_byte),
    .record_end    (out_ch.record_end),
    .status        (out_ch.status),
    .at_boundary   (out_ch.at_boundary)
);
